// ===== rtl/bvie_pkg.sv =====
// ----------------------------------------------------------------------------
// bvie_pkg: shared types and constants for the blob velocity estimator
// Holds the item structs, register indexes and field widths.
// ----------------------------------------------------------------------------
`default_nettype none
package bvie_pkg;
    localparam int RATE_W = 18;
    localparam int HALF_W = 16;
    localparam int KEEP_W = 17;
    localparam int CFG_W  = 18;
    localparam int IDX_W  = 2;

    localparam logic [IDX_W-1:0] REG_SAMPLE_RATE = 2'd0;
    localparam logic [IDX_W-1:0] REG_HALF_GAIN   = 2'd1;
    localparam logic [IDX_W-1:0] REG_KEEP_GAIN   = 2'd2;

    typedef struct packed {
        logic               mode;
        logic [4:0]         slot;
        logic               new_blob;
        logic [31:0]        time_stamp;
        logic signed [15:0] x_pos;
        logic signed [15:0] z_pos;
        logic signed [31:0] vx_in;
        logic signed [31:0] vz_in;
        logic signed [31:0] accel_in;
    } t_in_item;

    typedef struct packed {
        logic [4:0]         slot_out;
        logic signed [15:0] x_out;
        logic signed [15:0] z_out;
        logic signed [31:0] vx_out;
        logic signed [31:0] vz_out;
        logic [30:0]        speed;
        logic signed [31:0] accel;
        logic               stale;
    } t_out_item;
endpackage
`default_nettype wire

// ===== rtl/bvie_scale_div.sv =====
// ----------------------------------------------------------------------------
// bvie_scale_div: bit-serial (|d| * rate) / dt, signed, saturated to 32 bits
// Shift-add multiply one bit per cycle, then restoring divide one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module bvie_scale_div
    import bvie_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic               i_neg,
    input  wire logic [33:0]        i_mag,
    input  wire logic [RATE_W-1:0]  i_rate,
    input  wire logic [31:0]        i_dt,
    output      logic               o_done,
    output      logic signed [31:0] o_q
);
    localparam logic [1:0] S_IDLE = 2'd0, S_MUL = 2'd1, S_DIV = 2'd2, S_OUT = 2'd3;
    logic [1:0]        r_st;
    logic [5:0]        r_cnt;
    logic [51:0]       r_prod;   // product, then dividend shifting out
    logic [33:0]       r_mcand;
    logic [RATE_W-1:0] r_mplr;
    logic [32:0]       r_rem;
    logic [51:0]       r_quo;
    logic              r_neg;
    logic [31:0]       r_dt;
    logic [32:0]       w_try;
    logic [33:0]       w_sub;

    always_comb begin
        w_try = {r_rem[31:0], r_prod[51]};
        w_sub = {1'b0, w_try} - {2'b0, r_dt};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
        end else begin
            case (r_st)
                S_IDLE: if (i_start) begin
                    r_st <= S_MUL; r_cnt <= 6'd0; r_prod <= '0;
                    r_mcand <= i_mag; r_mplr <= i_rate; r_neg <= i_neg; r_dt <= i_dt;
                end
                S_MUL: begin
                    // MSB-first shift-add over the rate bits
                    r_prod <= (r_prod << 1)
                        + (r_mplr[RATE_W-1] ? {18'd0, r_mcand} : 52'd0);
                    r_mplr <= r_mplr << 1;
                    if (r_cnt == 6'(RATE_W - 1)) begin
                        r_st <= S_DIV; r_cnt <= 6'd0; r_rem <= '0; r_quo <= '0;
                    end else begin
                        r_cnt <= r_cnt + 6'd1;
                    end
                end
                S_DIV: begin
                    if (!w_sub[33]) begin
                        r_rem <= w_sub[32:0]; r_quo <= {r_quo[50:0], 1'b1};
                    end else begin
                        r_rem <= w_try; r_quo <= {r_quo[50:0], 1'b0};
                    end
                    r_prod <= r_prod << 1;
                    if (r_cnt == 6'd51) r_st <= S_OUT;
                    else r_cnt <= r_cnt + 6'd1;
                end
                S_OUT: r_st <= S_IDLE;
                default: r_st <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        o_done = (r_st == S_OUT);
        if (r_neg) o_q = (r_quo > 52'h80000000) ? 32'sh80000000 : -$signed(r_quo[31:0]);
        else       o_q = (r_quo > 52'h7FFFFFFF) ? 32'sh7FFFFFFF : $signed(r_quo[31:0]);
    end
endmodule
`default_nettype wire

// ===== rtl/bvie_mac.sv =====
// ----------------------------------------------------------------------------
// bvie_mac: bit-serial IIR update half*(a+b) + keep*f, rounded, saturated
// Two shift-add products formed one multiplier bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module bvie_mac
    import bvie_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic signed [32:0] i_sum,
    input  wire logic signed [31:0] i_filt,
    input  wire logic [HALF_W-1:0]  i_half,
    input  wire logic [KEEP_W-1:0]  i_keep,
    output      logic               o_done,
    output      logic signed [31:0] o_y
);
    logic              r_busy, r_done;
    logic [4:0]        r_cnt;
    logic signed [55:0] r_acc;
    logic signed [32:0] r_a;
    logic signed [31:0] r_f;
    logic [HALF_W-1:0] r_h;
    logic [KEEP_W-1:0] r_k;
    logic signed [55:0] w_t;
    logic signed [39:0] w_r;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1; r_cnt <= 5'd0; r_acc <= '0;
                r_a <= i_sum; r_f <= i_filt;
                r_h <= i_half; r_k <= i_keep;
            end else if (r_busy) begin
                // keep has one more bit than half; half is aligned below it
                r_acc <= (r_acc <<< 1)
                    + (r_k[KEEP_W-1] ? 56'(r_f) : 56'sd0)
                    + ((r_cnt != 5'd0 && r_h[HALF_W-1]) ? 56'(r_a) : 56'sd0);
                r_k <= r_k << 1;
                if (r_cnt != 5'd0) r_h <= r_h << 1;
                if (r_cnt == 5'(KEEP_W - 1)) begin
                    r_busy <= 1'b0; r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 5'd1;
                end
            end
        end
    end

    always_comb begin
        w_t = r_acc + 56'sd32768;
        w_r = 40'(w_t >>> 16);   // arithmetic shift = floor, matches round rule
        o_done = r_done;
        if (w_r > 40'sh007FFFFFFF)       o_y = 32'sh7FFFFFFF;
        else if (w_r < -40'sh0080000000) o_y = 32'sh80000000;
        else                             o_y = w_r[31:0];
    end
endmodule
`default_nettype wire

// ===== rtl/blob_velocity_iir_estimator.sv =====
// ----------------------------------------------------------------------------
// blob_velocity_iir_estimator: per-slot touch-blob velocity and speed estimator
// Finite-difference velocity, first-order IIR smoothing, speed and accel.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel i_in_valid/o_in_ready carries one blob update item; output
//   channel o_out_valid/i_out_ready carries one result item per input item.
//   Config writes (i_cfg_we, i_cfg_idx, i_cfg_data) are registered; write
//   them only while the block is idle.
//   One item is worked at a time. From acceptance to o_out_valid, mode 1
//   or stale items pass read, decode and write-back; derive items pass the
//   bit-serial units in turn: read and decode, x and z scale/divide in
//   parallel (18 multiply steps, 52 divide steps, start and handoff), the
//   IIR pair (17 steps), sum of squares, square root (one result bit per
//   cycle), accel scale/divide and write-back. The next item can be
//   accepted in the cycle after the result is latched.
//   The result sits in an output register; the next item is accepted as soon
//   as the result is latched, even while the receiver stalls, and is held
//   at the write-back stage until the register frees.
//   Reset clears control and starts a clearing pass through every entry of
//   the slot table; no item is accepted until it ends.
// ----------------------------------------------------------------------------
`default_nettype none
module blob_velocity_iir_estimator
    import bvie_pkg::*;
#(
    parameter int SLOTS = 32
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output      logic            o_in_ready,
    input  wire t_in_item        i_in_item,
    output      logic            o_out_valid,
    input  wire logic            i_out_ready,
    output      t_out_item       o_out_item,
    input  wire logic            i_cfg_we,
    input  wire logic [IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0] i_cfg_data
);
    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    localparam logic [3:0] S_CLR = 4'd0, S_IDLE = 4'd1, S_RD = 4'd2, S_DEC = 4'd3,
                           S_DX = 4'd4, S_MAC = 4'd5, S_SQ = 4'd6, S_SQ2 = 4'd7,
                           S_ACC = 4'd8, S_WB = 4'd9;

    // table entry layout
    typedef struct packed {
        logic [31:0]        stamp;
        logic signed [15:0] x;
        logic signed [15:0] z;
        logic signed [31:0] rvx, fvx, rvz, fvz, spd, acc;
    } t_entry;

    t_entry r_mem [SLOTS];
    t_entry r_rd, n_wr;

    logic [3:0]        r_st;
    logic [SW:0]       r_clr;
    logic [RATE_W-1:0] r_rate;
    logic [HALF_W-1:0] r_half;
    logic [KEEP_W-1:0] r_keep;
    t_in_item          r_in;
    logic [SW-1:0]     r_idx;
    t_entry            r_old, r_new;
    logic [31:0]       r_dt;
    logic              r_stale;
    logic              r_ov;
    t_out_item         r_out;
    // square root state
    logic [63:0]       r_sqv, r_res;
    logic [5:0]        r_sqc;
    logic [63:0]       r_bit;

    logic [31:0]       w_ostamp;
    logic              w_stale;
    logic              w_wb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate <= 18'd48000; r_half <= 16'd1024; r_keep <= 17'd63488;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_SAMPLE_RATE: r_rate <= i_cfg_data[RATE_W-1:0];
                REG_HALF_GAIN:   r_half <= i_cfg_data[HALF_W-1:0];
                REG_KEEP_GAIN:   r_keep <= i_cfg_data[KEEP_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- decode: old entry, stale check, next entry
    assign w_ostamp = r_in.new_blob ? 32'd0 : r_rd.stamp;
    assign w_stale  = !r_in.mode && (r_in.time_stamp <= w_ostamp);

    always_comb begin
        n_wr = r_in.new_blob ? '0 : r_rd;
        n_wr.x = r_in.x_pos;
        n_wr.z = r_in.z_pos;
        if (r_in.mode) begin
            n_wr.stamp = r_in.time_stamp;
            n_wr.rvx = '0; n_wr.rvz = '0; n_wr.spd = '0;
            n_wr.fvx = r_in.vx_in; n_wr.fvz = r_in.vz_in;
            n_wr.acc = r_in.accel_in;
        end else if (!w_stale) begin
            n_wr.stamp = r_in.time_stamp;
        end
    end

    // ---------------- serial units
    logic        w_dstart, w_astart, w_mstart;
    logic        w_dxd, w_dzd, w_mxd, w_mzd;
    logic signed [31:0] w_qx, w_qz, w_yx, w_yz;
    logic signed [16:0] w_dx, w_dz;
    logic signed [32:0] w_ds;
    logic signed [33:0] w_sel;

    assign w_dx = 17'(r_in.x_pos) - 17'(r_old.x);
    assign w_dz = 17'(r_in.z_pos) - 17'(r_old.z);
    assign w_ds = 33'(r_new.spd) - 33'(r_old.spd);
    assign w_sel = w_dstart ? 34'(w_dx) : 34'(w_ds);

    bvie_scale_div u_div_x (
        .i_clk, .i_rst_n, .i_start(w_dstart | w_astart),
        .i_neg(w_sel[33]),
        .i_mag(w_sel[33] ? 34'(-w_sel) : 34'(w_sel)),
        .i_rate(r_rate), .i_dt(r_dt), .o_done(w_dxd), .o_q(w_qx));
    bvie_scale_div u_div_z (
        .i_clk, .i_rst_n, .i_start(w_dstart), .i_neg(w_dz[16]),
        .i_mag(w_dz[16] ? 34'(-34'(w_dz)) : 34'(w_dz)),
        .i_rate(r_rate), .i_dt(r_dt), .o_done(w_dzd), .o_q(w_qz));
    bvie_mac u_mac_x (
        .i_clk, .i_rst_n, .i_start(w_mstart),
        .i_sum(33'(r_new.rvx) + 33'(r_old.rvx)), .i_filt(r_old.fvx),
        .i_half(r_half), .i_keep(r_keep), .o_done(w_mxd), .o_y(w_yx));
    bvie_mac u_mac_z (
        .i_clk, .i_rst_n, .i_start(w_mstart),
        .i_sum(33'(r_new.rvz) + 33'(r_old.rvz)), .i_filt(r_old.fvz),
        .i_half(r_half), .i_keep(r_keep), .o_done(w_mzd), .o_y(w_yz));

    assign w_dstart = (r_st == S_DX) && (r_sqc == 6'd0);
    assign w_astart = (r_st == S_ACC) && (r_sqc == 6'd0);
    assign w_mstart = (r_st == S_MAC) && (r_sqc == 6'd0);

    // square: one 32x32 product per cycle, registered
    logic [63:0] w_sq;
    assign w_sq = (r_sqc[0] == 1'b0)
        ? 64'($signed(r_new.fvx) * $signed(r_new.fvx))
        : 64'($signed(r_new.fvz) * $signed(r_new.fvz));
    logic [63:0] w_rb;
    assign w_rb = r_res + r_bit;

    assign o_in_ready  = (r_st == S_IDLE);
    assign o_out_valid = r_ov;
    assign o_out_item  = r_out;

    // result latched at write-back once the output register is free
    assign w_wb = (r_st == S_WB) && (!r_ov || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_wb) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_CLR; r_clr <= '0; r_sqc <= '0;
        end else begin
            case (r_st)
                S_CLR: begin
                    r_mem[r_clr[SW-1:0]] <= '0;
                    if (r_clr == (SW+1)'(SLOTS - 1)) r_st <= S_IDLE;
                    r_clr <= r_clr + 1'b1;
                end
                S_IDLE: if (i_in_valid) begin
                    r_in <= i_in_item;
                    r_idx <= SW'(i_in_item.slot % SLOTS);
                    r_st <= S_RD;
                end
                S_RD: begin
                    r_rd <= r_mem[r_idx];
                    r_st <= S_DEC;
                end
                S_DEC: begin
                    r_old <= r_in.new_blob ? '0 : r_rd;
                    r_new <= n_wr;
                    r_stale <= w_stale;
                    r_sqc <= '0;
                    r_dt <= r_in.time_stamp - w_ostamp;
                    if (r_in.mode || w_stale) r_st <= S_WB;
                    else r_st <= S_DX;
                end
                S_DX: begin
                    if (w_dxd) begin
                        r_new.rvx <= (r_rate == '0) ? 32'sd0 : w_qx;
                        r_new.rvz <= (r_rate == '0) ? 32'sd0 : w_qz;
                        r_sqc <= '0; r_st <= S_MAC;
                    end else begin
                        r_sqc <= 6'd1;
                    end
                end
                S_MAC: begin
                    if (w_mxd) begin
                        r_new.fvx <= w_yx; r_new.fvz <= w_yz;
                        r_sqc <= '0; r_st <= S_SQ;
                    end else begin
                        r_sqc <= 6'd1;
                    end
                end
                S_SQ: begin
                    // sum of squares: fvx squared, then fvz squared added
                    if (r_sqc == 6'd0) begin
                        r_sqv <= w_sq; r_sqc <= 6'd1;
                    end else begin
                        r_sqv <= r_sqv + w_sq;
                        r_res <= '0; r_bit <= 64'h4000000000000000;
                        r_sqc <= '0; r_st <= S_SQ2;
                    end
                end
                S_SQ2: begin
                    // one result bit per cycle
                    if (r_sqv >= w_rb) begin
                        r_sqv <= r_sqv - w_rb;
                        r_res <= (r_res >> 1) + r_bit;
                    end else begin
                        r_res <= r_res >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    if (r_bit[0]) begin
                        r_st <= S_ACC; r_sqc <= '0;
                        r_new.spd <= ((r_sqv >= w_rb) ? (r_res >> 1) + r_bit : r_res >> 1)
                            > 64'h7FFFFFFF ? 32'sh7FFFFFFF
                            : ((r_sqv >= w_rb) ? 32'((r_res >> 1) + r_bit)
                                               : 32'(r_res >> 1));
                    end
                end
                S_ACC: begin
                    if (w_dxd && r_sqc != 6'd0) begin
                        r_new.acc <= (r_rate == '0) ? 32'sd0 : w_qx;
                        r_sqc <= '0; r_st <= S_WB;
                    end else begin
                        r_sqc <= 6'd1;
                    end
                end
                S_WB: if (w_wb) begin
                    r_mem[r_idx] <= r_new;
                    r_out.slot_out <= r_in.slot;
                    r_out.x_out <= r_in.x_pos; r_out.z_out <= r_in.z_pos;
                    r_out.vx_out <= r_new.fvx; r_out.vz_out <= r_new.fvz;
                    r_out.speed <= r_new.spd[30:0];
                    r_out.accel <= r_new.acc;
                    r_out.stale <= r_stale;
                    r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire
